@@ rtl/slid_pkg.sv @@
`timescale 1ns / 1ps

package slid_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int DATA_W       = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] entry;
        logic [1:0]               status;
        logic                     last;
    } t_res;

endpackage

@@ rtl/slid_ram.sv @@
`timescale 1ns / 1ps

module slid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sorted_list_insert_delete_top.sv @@
`timescale 1ns / 1ps

// channel   ports                      handshake
// request   i_req (op, value)          taken when start high and busy low
// result    o_res (entry, status, last) one cycle, marked by o_strobe
//
// entries live in one ram (registered read); the list length is a register
// insert: 1 result; full or empty are early exits, else entries are shifted up, then written
// delete: reads every entry, moving the later ones down; read out: results 1 a cycle
// op 3 and early-exit cases answer on the cycle after the request
// synchronous active-low reset empties the list; no clearing pass
// results cannot be stalled; a new request may be taken while a result shows

module sorted_list_insert_delete_top #(
    parameter int CAPACITY = slid_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  slid_pkg::t_req    i_req,
    output logic              o_strobe,
    output slid_pkg::t_res    o_res
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = slid_pkg::DATA_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_HEADW,
        ST_SHIFT,
        ST_FIN,
        ST_DEL,
        ST_OUT
    } t_state;

    t_state              r_st, n_st;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_dptr, n_dptr;
    logic                r_iss, n_iss;
    logic                r_up, n_up;
    logic                r_dv, n_dv;
    logic                r_head, n_head;
    logic                r_found, n_found;
    logic signed [DW-1:0] r_val, n_val;
    logic                r_strobe, n_strobe;
    slid_pkg::t_res      r_res, n_res;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DW-1:0]       ram_wdata;
    logic [DW-1:0]       ram_rdata;
    logic [AW-1:0]       last_idx;
    logic                acc;
    logic                match;

    slid_ram #(
        .WIDTH(DW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    assign busy     = (r_st != ST_IDLE);
    assign acc      = start && !busy;
    assign last_idx = AW'(r_count - CW'(1));
    assign match    = (ram_rdata == r_val);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    always_comb begin
        n_st      = r_st;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_iss     = r_iss;
        n_up      = r_up;
        n_head    = r_head;
        n_found   = r_found;
        n_val     = r_val;
        n_strobe  = 1'b0;
        n_res     = r_res;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = r_val;

        // read address walk
        if (r_iss) begin
            if (r_up) begin
                if (r_ptr == last_idx) begin
                    n_iss = 1'b0;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end else begin
                if (r_ptr == '0) begin
                    n_iss = 1'b0;
                end else begin
                    n_ptr = r_ptr - AW'(1);
                end
            end
        end

        unique case (r_st)
            ST_IDLE: begin
                if (acc) begin
                    n_val = i_req.value;
                    case (i_req.op)
                        slid_pkg::OP_INSERT: begin
                            if (r_count == CW'(CAPACITY)) begin
                                n_strobe = 1'b1;
                                n_res    = '{entry: i_req.value,
                                             status: slid_pkg::STAT_FULL, last: 1'b1};
                            end else if (r_count == '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = i_req.value;
                                n_count   = CW'(1);
                                n_strobe  = 1'b1;
                                n_res     = '{entry: i_req.value,
                                              status: slid_pkg::STAT_OK, last: 1'b1};
                            end else begin
                                n_st  = ST_HEAD;
                                n_ptr = '0;
                            end
                        end
                        slid_pkg::OP_DELETE: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_res    = '{entry: i_req.value,
                                             status: slid_pkg::STAT_EMPTY, last: 1'b1};
                            end else begin
                                n_st    = ST_DEL;
                                n_ptr   = '0;
                                n_iss   = 1'b1;
                                n_up    = 1'b1;
                                n_found = 1'b0;
                            end
                        end
                        slid_pkg::OP_READ: begin
                            if (r_count == '0) begin
                                n_strobe = 1'b1;
                                n_res    = '{entry: '0,
                                             status: slid_pkg::STAT_EMPTY, last: 1'b1};
                            end else begin
                                n_st  = ST_OUT;
                                n_ptr = '0;
                                n_iss = 1'b1;
                                n_up  = 1'b1;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_res    = '{entry: i_req.value,
                                         status: slid_pkg::STAT_OK, last: 1'b1};
                        end
                    endcase
                end
            end
            ST_HEAD: begin
                n_st  = ST_HEADW;
                n_ptr = last_idx;
                n_iss = 1'b1;
                n_up  = 1'b0;
            end
            ST_HEADW: begin
                n_head = ($signed(r_val) <= $signed(ram_rdata));
                n_st   = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (r_dv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_dptr + AW'(1);
                    if (r_head || ($signed(ram_rdata) > $signed(r_val))) begin
                        ram_wdata = ram_rdata;
                        if (r_dptr == '0) begin
                            n_st = ST_FIN;
                        end
                    end else begin
                        ram_wdata = r_val;
                        n_count   = r_count + CW'(1);
                        n_strobe  = 1'b1;
                        n_res     = '{entry: r_val, status: slid_pkg::STAT_OK, last: 1'b1};
                        n_st      = ST_IDLE;
                        n_iss     = 1'b0;
                    end
                end
            end
            ST_FIN: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = r_val;
                n_count   = r_count + CW'(1);
                n_strobe  = 1'b1;
                n_res     = '{entry: r_val, status: slid_pkg::STAT_OK, last: 1'b1};
                n_st      = ST_IDLE;
                n_iss     = 1'b0;
            end
            ST_DEL: begin
                if (r_dv) begin
                    if (r_found) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_dptr - AW'(1);
                        ram_wdata = ram_rdata;
                    end else if (match) begin
                        n_found = 1'b1;
                    end
                    if (r_dptr == last_idx) begin
                        n_strobe = 1'b1;
                        n_st     = ST_IDLE;
                        n_iss    = 1'b0;
                        if (r_found || match) begin
                            n_count = r_count - CW'(1);
                            n_res   = '{entry: r_val, status: slid_pkg::STAT_OK, last: 1'b1};
                        end else begin
                            n_res   = '{entry: r_val,
                                        status: slid_pkg::STAT_NOT_FOUND, last: 1'b1};
                        end
                    end
                end
            end
            ST_OUT: begin
                if (r_dv) begin
                    n_strobe = 1'b1;
                    n_res    = '{entry: ram_rdata, status: slid_pkg::STAT_OK,
                                 last: (r_dptr == last_idx)};
                    if (r_dptr == last_idx) begin
                        n_st  = ST_IDLE;
                        n_iss = 1'b0;
                    end
                end
            end
            default: begin
                n_st  = ST_IDLE;
                n_iss = 1'b0;
            end
        endcase

        n_dv   = r_iss && (n_st != ST_IDLE);
        n_dptr = r_ptr;
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_dptr  <= n_dptr;
        r_up    <= n_up;
        r_head  <= n_head;
        r_found <= n_found;
        r_val   <= n_val;
        r_res   <= n_res;
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_count  <= '0;
            r_iss    <= 1'b0;
            r_dv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_st     <= n_st;
            r_count  <= n_count;
            r_iss    <= n_iss;
            r_dv     <= n_dv;
            r_strobe <= n_strobe;
        end
    end

endmodule
